// ===== rtl/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and helpers for the Playfair digraph encrypter
// Letter codes, item structs, digraph queue entries and letter helpers.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int LETTER_W   = 5;
	localparam int POS_W      = 3;
	localparam int SIDE       = 5;
	localparam int CELLS      = SIDE * SIDE;
	localparam int SQUARE_W   = CELLS * LETTER_W;
	localparam int CFG_W      = 45;
	localparam int CFG_LAST_W = 35;
	localparam int CFG_IDX_W  = 2;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef logic [LETTER_W-1:0] letter_t;

	localparam letter_t LETTER_I   = 5'd8;
	localparam letter_t LETTER_J   = 5'd9;
	localparam letter_t LETTER_Q   = 5'd16;
	localparam letter_t LETTER_X   = 5'd23;
	localparam letter_t LETTER_MAX = 5'd25;

	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_MIDDLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_LAST   = 2'd2;

	typedef struct packed {
		letter_t plain_letter;
		logic    final_letter;
	} in_item_t;

	typedef struct packed {
		letter_t cipher_letter;
		logic    run_end;
	} out_item_t;

	// One digraph to encrypt; last marks the final pair of an input item.
	typedef struct packed {
		letter_t first;
		letter_t second;
		logic    last;
	} pair_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_t;

	// Saturate out-of-range codes to Z, fold J onto I.
	function automatic letter_t normalize(letter_t l);
		letter_t v;
		v = (l > LETTER_MAX) ? LETTER_MAX : l;
		if (v == LETTER_J) begin
			v = LETTER_I;
		end
		return v;
	endfunction

	function automatic letter_t pad_for(letter_t l);
		return (l == LETTER_X) ? LETTER_Q : LETTER_X;
	endfunction

	function automatic letter_t saturate(letter_t l);
		return (l > LETTER_MAX) ? LETTER_MAX : l;
	endfunction

endpackage

// ===== rtl/playfair_digraph_encrypt.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt: streaming Playfair encrypter
// Pairs plaintext letters into digraphs and encrypts them with a 5x5 key square.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready, in_item = {plain_letter, final_letter}.
//                 Codes above Z saturate to Z, J is folded onto I.
//   out channel : out_valid/out_ready, out_item = {cipher_letter, run_end};
//                 run_end flags the last letter caused by an input item.
//   cfg channel : cfg_valid/cfg_ready (always ready), cfg_index selects the
//                 cells 0-8, 9-17 or 18-24 word, five bits per cell; other
//                 indexes are dropped. Write only while the block is idle.
// Timing:
//   An item's first letter passes the digraph queue, the locate and transform
//   stages and the output register; then one letter per cycle follows while
//   out_ready holds, a digraph's two letters sharing the single square read
//   port. A doubled final letter (four letters) stalls input for its spill.
// Reset clears the pending letter, the queue, the pipeline and the square.
// A stalled receiver holds the output item; the digraph queue keeps taking
// items until it fills, then in_ready drops.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt #(
	parameter int QUEUE_DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pfe_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pfe_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfe_pkg::CFG_W-1:0]       cfg_data
);
	import pfe_pkg::*;

	logic [CFG_W-1:0]      sq_first_q;
	logic [CFG_W-1:0]      sq_middle_q;
	logic [CFG_LAST_W-1:0] sq_last_q;
	logic [SQUARE_W-1:0]   square;

	logic  wr_valid, wr_ready, rd_valid, rd_ready;
	pair_t wr_item, rd_item;

	assign cfg_ready = 1'b1;

	// hold the key square; cell k sits at bits 5k of the joined word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_first_q  <= '0;
			sq_middle_q <= '0;
			sq_last_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CELLS_FIRST:  sq_first_q  <= cfg_data;
				CFG_CELLS_MIDDLE: sq_middle_q <= cfg_data;
				CFG_CELLS_LAST:   sq_last_q   <= cfg_data[CFG_LAST_W-1:0];
				default: ;
			endcase
		end
	end

	assign square = {sq_last_q, sq_middle_q, sq_first_q};

	// front: form digraphs from the letter stream
	pfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_item  (wr_item)
	);

	// decouple intake from encryption
	pfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_item  (wr_item),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_item  (rd_item)
	);

	// back: encrypt each digraph, emit one letter per cycle unless out_ready stalls
	pfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.square    (square),
		.rd_valid  (rd_valid),
		.rd_ready  (rd_ready),
		.rd_item   (rd_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/pfe_front.sv =====
// ----------------------------------------------------------------------------
// pfe_front: letter intake and digraph former
// Holds the pending letter, inserts pads and pushes digraphs to the queue.
// ----------------------------------------------------------------------------
module pfe_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pfe_pkg::in_item_t in_item,
	output logic           wr_valid,
	input  logic           wr_ready,
	output pfe_pkg::pair_t wr_item
);
	import pfe_pkg::*;

	letter_t held_q;
	logic    holding_q;
	pair_t   spill_q;
	logic    spill_valid_q;

	letter_t norm;
	logic    fin;
	logic    accept;
	logic    push_now;
	pair_t   pair_now;
	logic    make_spill;

	assign norm     = normalize(in_item.plain_letter);
	assign fin      = in_item.final_letter;
	assign in_ready = !spill_valid_q && wr_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push_now   = 1'b0;
		make_spill = 1'b0;
		pair_now   = '{first: norm, second: pad_for(norm), last: 1'b1};
		if (!holding_q) begin
			push_now = fin;
		end else if (held_q != norm) begin
			push_now = 1'b1;
			pair_now = '{first: held_q, second: norm, last: 1'b1};
		end else begin
			push_now   = 1'b1;
			make_spill = fin;
			pair_now   = '{first: held_q, second: pad_for(held_q), last: !fin};
		end
	end

	// spill holds the second digraph of a doubled final letter
	assign wr_valid = spill_valid_q || (accept && push_now);
	assign wr_item  = spill_valid_q ? spill_q : pair_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= '0;
			holding_q     <= 1'b0;
			spill_valid_q <= 1'b0;
		end else begin
			if (spill_valid_q && wr_ready) begin
				spill_valid_q <= 1'b0;
			end
			if (accept) begin
				if (!holding_q) begin
					held_q    <= norm;
					holding_q <= !fin;
				end else if (held_q != norm) begin
					holding_q <= 1'b0;
				end else begin
					held_q        <= norm;
					holding_q     <= !fin;
					spill_valid_q <= make_spill;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && make_spill) begin
			spill_q <= '{first: norm, second: pad_for(norm), last: 1'b1};
		end
	end

endmodule

// ===== rtl/pfe_queue.sv =====
// ----------------------------------------------------------------------------
// pfe_queue: digraph queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module pfe_queue #(
	parameter int DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  pfe_pkg::pair_t wr_item,
	output logic           rd_valid,
	input  logic           rd_ready,
	output pfe_pkg::pair_t rd_item
);
	import pfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pair_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign rd_item  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== rtl/pfe_back.sv =====
// ----------------------------------------------------------------------------
// pfe_back: digraph encryption pipeline
// Finds both letters, applies square rules; one letter a cycle if unstalled.
// ----------------------------------------------------------------------------
module pfe_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pfe_pkg::SQUARE_W-1:0]   square,
	input  logic                           rd_valid,
	output logic                           rd_ready,
	input  pfe_pkg::pair_t                 rd_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pfe_pkg::out_item_t             out_item
);
	import pfe_pkg::*;

	localparam logic [POS_W-1:0] SIDE_LAST = POS_W'(SIDE - 1);

	function automatic pos_t find_pos(letter_t l, logic [SQUARE_W-1:0] sq);
		pos_t p;
		p = '0;
		// scan backward so the first matching cell wins
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (sq[(r * SIDE + c) * LETTER_W +: LETTER_W] == l) begin
					p.row = POS_W'(r);
					p.col = POS_W'(c);
				end
			end
		end
		return p;
	endfunction

	function automatic logic [POS_W-1:0] wrap_inc(logic [POS_W-1:0] v);
		return (v == SIDE_LAST) ? '0 : v + 1'b1;
	endfunction

	letter_t cells [CELLS];

	pos_t      pa_s1, pb_s1;
	logic      last_s1, valid_s1;
	pos_t      ta_s2, tb_s2;
	logic      last_s2, valid_s2, sel_s2;
	out_item_t out_q;
	logic      out_valid_q;

	pos_t             ta_next, tb_next, t_read;
	logic [4:0]       cell_idx;
	logic             out_load, s2_free, s1_move, s1_free;

	always_comb begin
		for (int k = 0; k < CELLS; k++) begin
			cells[k] = square[k * LETTER_W +: LETTER_W];
		end
	end

	// same row: shift right; same column: shift down; else swap corners
	always_comb begin
		if (pa_s1.row == pb_s1.row) begin
			ta_next = '{row: pa_s1.row, col: wrap_inc(pa_s1.col)};
			tb_next = '{row: pb_s1.row, col: wrap_inc(pb_s1.col)};
		end else if (pa_s1.col == pb_s1.col) begin
			ta_next = '{row: wrap_inc(pa_s1.row), col: pa_s1.col};
			tb_next = '{row: wrap_inc(pb_s1.row), col: pb_s1.col};
		end else begin
			ta_next = '{row: pa_s1.row, col: pb_s1.col};
			tb_next = '{row: pb_s1.row, col: pa_s1.col};
		end
	end

	assign t_read   = sel_s2 ? tb_s2 : ta_s2;
	assign cell_idx = {t_read.row[2:0], 2'b00} + {2'b00, t_read.row[2:0]}
		+ {2'b00, t_read.col[2:0]};

	assign out_load = valid_s2 && (!out_valid_q || out_ready);
	assign s2_free  = !valid_s2 || (out_load && sel_s2);
	assign s1_move  = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s1_move;
	assign rd_ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			sel_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= rd_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_load) begin
				sel_s2 <= !sel_s2;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid && s1_free) begin
			pa_s1   <= find_pos(rd_item.first, square);
			pb_s1   <= find_pos(rd_item.second, square);
			last_s1 <= rd_item.last;
		end
		if (s1_move) begin
			ta_s2   <= ta_next;
			tb_s2   <= tb_next;
			last_s2 <= last_s1;
		end
		if (out_load) begin
			out_q.cipher_letter <= saturate(cells[cell_idx]);
			out_q.run_end       <= sel_s2 && last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
